// ===== rtl/rap_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rap_pkg;

  // default width of the declared argument length
  localparam int unsigned RAP_ARG_LEN_BITS = 20;
  // default depth of each internal queue (power of two, at least 2)
  localparam int unsigned RAP_QUEUE_DEPTH  = 2;

  // protocol characters
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NO_STAR   = 3'd0;
  localparam logic [2:0] ERR_COUNT     = 3'd1;
  localparam logic [2:0] ERR_NO_DOLLAR = 3'd2;
  localparam logic [2:0] ERR_TOO_LONG  = 3'd3;
  localparam logic [2:0] ERR_TRUNC     = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_start;
    logic       buffer_end;
  } in_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic [3:0] arg_index;
    logic       arg_end;
    logic       request_end;
    logic [2:0] error_code;
  } out_word_t;

  // byte with its character class, front to back
  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_start;
    logic       buffer_end;
    logic       is_star;
    logic       is_dollar;
    logic       is_cr;
    logic       is_digit;
    logic       is_nz_digit;
    logic [3:0] digit;
  } cls_word_t;

endpackage
`default_nettype wire

// ===== rtl/rap_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rap_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = PW + 1;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             push_ok, pop_ok;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign push_ok = push & ~full;
  assign pop_ok  = pop & ~empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push_ok ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop_ok ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r + CW'(push_ok) - CW'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rap_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rap_front
  import rap_pkg::*;
(
  input  wire in_word_t in_word,
  output cls_word_t     cls_word
);

  logic [7:0] b;

  assign b = in_word.data_byte;

  always_comb begin
    cls_word.data_byte    = b;
    cls_word.buffer_start = in_word.buffer_start;
    cls_word.buffer_end   = in_word.buffer_end;
    cls_word.is_star      = (b == CH_STAR);
    cls_word.is_dollar    = (b == CH_DOLLAR);
    cls_word.is_cr        = (b == CH_CR);
    cls_word.is_digit     = (b >= CH_ZERO) && (b <= CH_NINE);
    cls_word.is_nz_digit  = (b >= CH_ONE) && (b <= CH_NINE);
    // ascii digits sit at 0x30..0x39, so the low nibble is the value
    cls_word.digit        = b[3:0];
  end

endmodule
`default_nettype wire

// ===== rtl/rap_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rap_back
  import rap_pkg::*;
#(
  parameter int unsigned ARG_LEN_BITS = RAP_ARG_LEN_BITS
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [ARG_LEN_BITS-1:0] cfg_data,
  input  wire logic                    item_valid,
  input  wire cls_word_t               item,
  output logic                         item_pop,
  input  wire logic                    res_full,
  output logic                         res_push,
  output out_word_t                    res_word
);

  localparam int unsigned LW = ARG_LEN_BITS + 1;
  localparam int unsigned PW = ARG_LEN_BITS + 5;
  localparam logic [LW-1:0] LEN_CAP = LW'(1) << ARG_LEN_BITS;

  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_STAR   = 4'd1;
  localparam logic [3:0] PH_COUNT  = 4'd2;
  localparam logic [3:0] PH_HSKIP  = 4'd3;
  localparam logic [3:0] PH_HLF    = 4'd4;
  localparam logic [3:0] PH_DOLLAR = 4'd5;
  localparam logic [3:0] PH_LFIRST = 4'd6;
  localparam logic [3:0] PH_LDIG   = 4'd7;
  localparam logic [3:0] PH_LSKIP  = 4'd8;
  localparam logic [3:0] PH_LLF    = 4'd9;
  localparam logic [3:0] PH_PAY    = 4'd10;
  localparam logic [3:0] PH_TRAIL  = 4'd11;

  logic [ARG_LEN_BITS-1:0] max_len_r;
  logic [3:0]              phase_r, phase_nxt;
  logic [3:0]              args_r, args_nxt;
  logic [3:0]              cur_r, cur_nxt;
  logic [LW-1:0]           len_r, len_nxt;
  logic [ARG_LEN_BITS-1:0] pay_r, pay_nxt;
  logic [1:0]              skip_r, skip_nxt;

  logic                    fire;
  logic [3:0]              ph, al, ca;
  logic [LW-1:0]           la;
  logic [ARG_LEN_BITS-1:0] pl;
  logic [1:0]              sk;
  logic [PW-1:0]           len_prod;
  logic                    last;
  out_word_t               w;
  logic                    have;

  assign fire     = item_valid & ~res_full;
  assign item_pop = fire;
  assign res_push = fire & have;
  assign res_word = w;

  // accumulator times ten plus the new digit
  assign len_prod = (PW'(la) << 3) + (PW'(la) << 1) + PW'(item.digit);
  assign last     = (al <= 4'd1);

  always_comb begin
    phase_nxt = phase_r;
    args_nxt  = args_r;
    cur_nxt   = cur_r;
    len_nxt   = len_r;
    pay_nxt   = pay_r;
    skip_nxt  = skip_r;
    have      = 1'b0;
    w         = '0;
    // a buffer start restarts the parser at the '*' position
    ph = item.buffer_start ? PH_STAR : phase_r;
    al = item.buffer_start ? 4'd0 : args_r;
    ca = item.buffer_start ? 4'd0 : cur_r;
    la = item.buffer_start ? '0 : len_r;
    pl = item.buffer_start ? '0 : pay_r;
    sk = item.buffer_start ? 2'd0 : skip_r;
    if (fire) begin
      phase_nxt = ph;
      args_nxt  = al;
      cur_nxt   = ca;
      len_nxt   = la;
      pay_nxt   = pl;
      skip_nxt  = sk;
      case (ph)
        PH_STAR: begin
          if (item.is_star) begin
            phase_nxt = PH_COUNT;
          end else begin
            have = 1'b1; w.kind = KIND_ERROR; w.error_code = ERR_NO_STAR;
            w.arg_index = ca; phase_nxt = PH_IDLE;
          end
        end
        PH_COUNT: begin
          if (item.is_digit) begin
            args_nxt  = item.digit;
            cur_nxt   = 4'd0;
            phase_nxt = PH_HSKIP;
          end else begin
            have = 1'b1; w.kind = KIND_ERROR; w.error_code = ERR_COUNT;
            w.arg_index = ca; phase_nxt = PH_IDLE;
          end
        end
        PH_HSKIP: begin
          if (item.is_cr) begin
            phase_nxt = PH_HLF;
          end
        end
        PH_HLF: begin
          phase_nxt = (al != 4'd0) ? PH_DOLLAR : PH_IDLE;
        end
        PH_DOLLAR: begin
          if (item.is_dollar) begin
            phase_nxt = PH_LFIRST;
          end else begin
            have = 1'b1; w.kind = KIND_ERROR; w.error_code = ERR_NO_DOLLAR;
            w.arg_index = ca; phase_nxt = PH_IDLE;
          end
        end
        PH_LFIRST: begin
          len_nxt = '0;
          if (item.is_nz_digit) begin
            len_nxt   = LW'(item.digit);
            phase_nxt = PH_LDIG;
          end else if (item.is_cr) begin
            phase_nxt = PH_LLF;
          end else begin
            phase_nxt = PH_LSKIP;
          end
        end
        PH_LDIG: begin
          if (item.is_digit) begin
            // saturate one past the largest legal length
            len_nxt = (len_prod > PW'(LEN_CAP)) ? LEN_CAP : len_prod[LW-1:0];
          end else if (item.is_cr) begin
            phase_nxt = PH_LLF;
          end else begin
            phase_nxt = PH_LSKIP;
          end
        end
        PH_LSKIP: begin
          if (item.is_cr) begin
            phase_nxt = PH_LLF;
          end
        end
        PH_LLF: begin
          if (la > LW'(max_len_r)) begin
            have = 1'b1; w.kind = KIND_ERROR; w.error_code = ERR_TOO_LONG;
            w.arg_index = ca; phase_nxt = PH_IDLE;
          end else if (la == '0) begin
            have = 1'b1; w.kind = KIND_EMPTY; w.arg_index = ca;
            w.arg_end = 1'b1; w.request_end = last;
            args_nxt = (al != 4'd0) ? al - 4'd1 : 4'd0;
            if (last) begin
              phase_nxt = PH_IDLE;
            end else begin
              cur_nxt = ca + 4'd1; skip_nxt = 2'd2; phase_nxt = PH_TRAIL;
            end
          end else begin
            pay_nxt   = la[ARG_LEN_BITS-1:0];
            phase_nxt = PH_PAY;
          end
        end
        PH_PAY: begin
          have = 1'b1; w.kind = KIND_PAYLOAD; w.payload_byte = item.data_byte;
          w.arg_index = ca;
          pay_nxt = pl - ARG_LEN_BITS'(1);
          if (pl == ARG_LEN_BITS'(1)) begin
            w.arg_end = 1'b1; w.request_end = last;
            args_nxt = (al != 4'd0) ? al - 4'd1 : 4'd0;
            if (last) begin
              phase_nxt = PH_IDLE;
            end else begin
              cur_nxt = ca + 4'd1; skip_nxt = 2'd2; phase_nxt = PH_TRAIL;
            end
          end
        end
        PH_TRAIL: begin
          skip_nxt = sk - 2'd1;
          if (sk == 2'd1) begin
            phase_nxt = PH_DOLLAR;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
      // end of buffer with a request still open overrides this byte's result
      if (item.buffer_end) begin
        if (phase_nxt != PH_IDLE) begin
          have = 1'b1;
          w    = '0;
          w.kind = KIND_ERROR; w.error_code = ERR_TRUNC; w.arg_index = cur_nxt;
        end
        phase_nxt = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= '1;
      phase_r   <= PH_IDLE;
      args_r    <= '0;
      cur_r     <= '0;
      len_r     <= '0;
      pay_r     <= '0;
      skip_r    <= '0;
    end else begin
      if (cfg_we) begin
        max_len_r <= cfg_data;
      end
      phase_r <= phase_nxt;
      args_r  <= args_nxt;
      cur_r   <= cur_nxt;
      len_r   <= len_nxt;
      pay_r   <= pay_nxt;
      skip_r  <= skip_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/request_array_byte_parser.sv =====
// Request array parser: takes a request buffer one byte per word on the in_
// queue interface and hands out argument payload bytes, empty-argument marks
// and error words on the out_ queue interface, at most one result word per
// byte. One byte per clock is sustained while the output queue has room: the
// front classifies the byte as it is pushed, a small queue decouples it from
// the back, and the back steps the parser state once per byte, writing any
// result into the output queue; both queues are registered. in_full rises
// only when the back is held off by a full output queue. After an error or
// a finished request, bytes are dropped until one carries buffer_start.
// cfg_data (largest legal argument length) must only be written while idle;
// it resets to all ones.
`timescale 1ns / 1ps
`default_nettype none
module request_array_byte_parser
  import rap_pkg::*;
#(
  parameter int unsigned ARG_LEN_BITS = RAP_ARG_LEN_BITS,
  parameter int unsigned QUEUE_DEPTH  = RAP_QUEUE_DEPTH
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // input word queue
  input  wire logic                    in_push,
  input  wire in_word_t                in_word,
  output logic                         in_full,
  // result word queue
  input  wire logic                    out_pop,
  output out_word_t                    out_word,
  output logic                         out_empty,
  // max argument length register
  input  wire logic                    cfg_we,
  input  wire logic [ARG_LEN_BITS-1:0] cfg_data
);

  localparam int unsigned CLS_W = $bits(cls_word_t);
  localparam int unsigned OUT_W = $bits(out_word_t);

  cls_word_t  front_word;
  cls_word_t  back_word;
  logic [CLS_W-1:0] back_bits;
  logic       item_empty;
  logic       item_pop;
  logic       res_full;
  logic       res_push;
  out_word_t  res_word;
  logic [OUT_W-1:0] out_bits;

  // classify each byte as it arrives
  rap_front u_front (
    .in_word  (in_word),
    .cls_word (front_word)
  );

  // decoupling queue between front and back
  rap_fifo #(
    .WIDTH (CLS_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_item_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (front_word),
    .full  (in_full),
    .pop   (item_pop),
    .rdata (back_bits),
    .empty (item_empty)
  );

  assign back_word = cls_word_t'(back_bits);

  // parser state machine, one byte per cycle when the result queue has room
  rap_back #(
    .ARG_LEN_BITS (ARG_LEN_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .item_valid (~item_empty),
    .item       (back_word),
    .item_pop   (item_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res_word   (res_word)
  );

  // result queue, its head drives the out_ ports
  rap_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_word),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_bits),
    .empty (out_empty)
  );

  assign out_word = out_word_t'(out_bits);

endmodule
`default_nettype wire

// ===== rtl/rap_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rap_chk
  import rap_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_full,
  input wire logic      out_pop,
  input wire out_word_t out_word,
  input wire logic      out_empty
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_word)))
    else $error("waiting result word changed");

  a_req_end: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_word.request_end) |-> out_word.arg_end)
    else $error("request end without argument end");

  a_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_word.kind != KIND_PAYLOAD) |->
      (out_word.payload_byte == 8'd0))
    else $error("payload byte on non-payload word");

  a_err_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_word.kind == KIND_ERROR) |->
      (!out_word.arg_end && !out_word.request_end))
    else $error("end marks on error word");

endmodule

bind request_array_byte_parser rap_chk u_chk (.*);
`default_nettype wire

// ===== sim/request_array_byte_parser_tb.sv =====
`timescale 1ns / 1ps
module request_array_byte_parser_tb;
  import rap_pkg::*;

  localparam int          LEN_CAP      = 1 << RAP_ARG_LEN_BITS;
  localparam logic [7:0]  LF_BYTE      = 8'h0A;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          RAND_PHASES  = 5;
  localparam int          PHASE_ITEMS  = 180;

  // parser phases, mirrored for the prediction
  typedef enum logic [3:0] {
    PH_IDLE, PH_STAR, PH_COUNT, PH_HSKIP, PH_HLF, PH_DOLLAR,
    PH_LFIRST, PH_LDIG, PH_LSKIP, PH_LLF, PH_PAY, PH_TRAIL
  } parse_phase_e;

  logic                        clk;
  logic                        rst_n;
  logic                        in_push;
  in_word_t                    in_word;
  logic                        in_full;
  logic                        out_pop;
  out_word_t                   out_word;
  logic                        out_empty;
  logic                        cfg_we;
  logic [RAP_ARG_LEN_BITS-1:0] cfg_data;

  request_array_byte_parser dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_word  (in_word),
    .in_full  (in_full),
    .out_pop  (out_pop),
    .out_word (out_word),
    .out_empty(out_empty),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // predicted parser state and length limit
  parse_phase_e                prs_phase;
  logic [3:0]                  args_left;
  logic [3:0]                  cur_arg;
  logic [RAP_ARG_LEN_BITS:0]   len_acc;
  logic [RAP_ARG_LEN_BITS-1:0] pay_left;
  logic [1:0]                  skip_left;
  logic [RAP_ARG_LEN_BITS-1:0] arg_len_limit;

  out_word_t expected_words[$];  // predicted result words, oldest first
  in_word_t  pend_q[$];          // request bytes waiting to be pushed

  // idling and hold-off knobs
  int unsigned send_gap_max;
  int unsigned recv_gap_max;
  int          rx_gap;
  int          hold_cycles;

  // run statistics
  int unsigned fail_count;
  int unsigned words_sent;
  int unsigned live_items;
  int unsigned stall_cycles;
  int unsigned results_checked;
  int unsigned payload_seen;
  int unsigned empty_seen;
  int unsigned errors_seen;
  int unsigned requests_built;
  int unsigned limit_writes;

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("request_array_byte_parser_tb NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic bit is_digit(input logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  // error word for the current argument; the parser drops to idle
  function automatic out_word_t error_word(input logic [2:0] code);
    out_word_t r;
    r = '0;
    r.kind       = KIND_ERROR;
    r.error_code = code;
    r.arg_index  = cur_arg;
    prs_phase    = PH_IDLE;
    return r;
  endfunction

  // end of an argument: idle after the last one, else skip two bytes
  function automatic bit close_arg();
    bit last;
    last = (args_left <= 1);
    if (args_left != 0) args_left = args_left - 1;
    if (last) begin
      prs_phase = PH_IDLE;
    end else begin
      cur_arg   = cur_arg + 1;
      skip_left = 2;
      prs_phase = PH_TRAIL;
    end
    return last;
  endfunction

  task automatic predict_word(input in_word_t w, output bit have, output out_word_t res);
    logic [7:0]  b;
    logic [3:0]  idx;
    logic [31:0] acc;
    b    = w.data_byte;
    have = 1'b0;
    res  = '0;
    if (w.buffer_start) begin
      prs_phase = PH_STAR;
      args_left = '0;
      cur_arg   = '0;
      len_acc   = '0;
      pay_left  = '0;
      skip_left = '0;
    end
    case (prs_phase)
      PH_STAR: begin
        if (b == CH_STAR) prs_phase = PH_COUNT;
        else begin
          res  = error_word(ERR_NO_STAR);
          have = 1'b1;
        end
      end
      PH_COUNT: begin
        if (is_digit(b)) begin
          args_left = b - CH_ZERO;
          cur_arg   = '0;
          prs_phase = PH_HSKIP;
        end else begin
          res  = error_word(ERR_COUNT);
          have = 1'b1;
        end
      end
      PH_HSKIP: if (b == CH_CR) prs_phase = PH_HLF;
      PH_HLF: prs_phase = (args_left != 0) ? PH_DOLLAR : PH_IDLE;
      PH_DOLLAR: begin
        if (b == CH_DOLLAR) prs_phase = PH_LFIRST;
        else begin
          res  = error_word(ERR_NO_DOLLAR);
          have = 1'b1;
        end
      end
      PH_LFIRST: begin
        // a leading zero or a non-digit both mean length zero
        len_acc = '0;
        if (b >= CH_ONE && b <= CH_NINE) begin
          len_acc   = b - CH_ZERO;
          prs_phase = PH_LDIG;
        end else if (b == CH_CR) prs_phase = PH_LLF;
        else prs_phase = PH_LSKIP;
      end
      PH_LDIG: begin
        if (is_digit(b)) begin
          // saturate one past the widest length so it always fails the limit
          acc     = len_acc * 10 + (b - CH_ZERO);
          len_acc = (acc > LEN_CAP) ? LEN_CAP : acc;
        end else if (b == CH_CR) prs_phase = PH_LLF;
        else prs_phase = PH_LSKIP;
      end
      PH_LSKIP: if (b == CH_CR) prs_phase = PH_LLF;
      PH_LLF: begin
        if (len_acc > arg_len_limit) begin
          res  = error_word(ERR_TOO_LONG);
          have = 1'b1;
        end else if (len_acc == 0) begin
          idx             = cur_arg;
          have            = 1'b1;
          res.kind        = KIND_EMPTY;
          res.arg_index   = idx;
          res.arg_end     = 1'b1;
          res.request_end = close_arg();
        end else begin
          pay_left  = len_acc[RAP_ARG_LEN_BITS-1:0];
          prs_phase = PH_PAY;
        end
      end
      PH_PAY: begin
        idx              = cur_arg;
        pay_left         = pay_left - 1;
        have             = 1'b1;
        res.kind         = KIND_PAYLOAD;
        res.payload_byte = b;
        res.arg_index    = idx;
        if (pay_left == 0) begin
          res.arg_end     = 1'b1;
          res.request_end = close_arg();
        end
      end
      PH_TRAIL: begin
        skip_left = skip_left - 1;
        if (skip_left == 0) prs_phase = PH_DOLLAR;
      end
      default: prs_phase = PH_IDLE;
    endcase
    // buffer end inside an unfinished request overrides whatever this byte gave
    if (w.buffer_end) begin
      if (prs_phase != PH_IDLE) begin
        res  = error_word(ERR_TRUNC);
        have = 1'b1;
      end
      prs_phase = PH_IDLE;
    end
  endtask

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // pushes one word and records what it should produce; enters and leaves
  // on a falling edge with in_push still high
  task automatic send_word(input in_word_t w);
    int unsigned gap;
    bit          have;
    out_word_t   res;
    gap = send_gap_max ? $urandom_range(0, send_gap_max) : 0;
    if (gap > 0) begin
      in_push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_word = w;
    in_push = 1'b1;
    @(posedge clk);
    while (in_full) begin
      stall_cycles++;
      @(posedge clk);
    end
    if (w.buffer_start || prs_phase != PH_IDLE) live_items++;
    predict_word(w, have, res);
    if (have) expected_words.push_back(res);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic put(input logic [7:0] b);
    in_word_t w;
    w           = '0;
    w.data_byte = b;
    pend_q.push_back(w);
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  // text then CR and the byte after it
  task automatic put_line(input string s);
    put_str(s);
    put(CH_CR);
    put(LF_BYTE);
  endtask

  // the two bytes that follow an argument payload
  task automatic put_trail();
    put(CH_CR);
    put(LF_BYTE);
  endtask

  task automatic flush_words(input bit start_first, input bit end_last);
    if (pend_q.size() != 0) begin
      if (start_first) pend_q[0].buffer_start = 1'b1;
      if (end_last) pend_q[pend_q.size()-1].buffer_end = 1'b1;
    end
    while (pend_q.size() != 0) send_word(pend_q.pop_front());
  endtask

  // stop pushing, wait out every predicted word, then let the pipe settle
  task automatic wait_idle();
    in_push = 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic [RAP_ARG_LEN_BITS-1:0] v);
    wait_idle();
    cfg_data = v;
    cfg_we   = 1'b1;
    @(negedge clk);
    cfg_we        = 1'b0;
    arg_len_limit = v;
    limit_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    out_word_t want;
    if (rst_n && out_pop && !out_empty) begin
      rx_gap = recv_gap_max ? $urandom_range(0, recv_gap_max) : 0;
      case (out_word.kind)
        KIND_PAYLOAD: payload_seen++;
        KIND_EMPTY:   empty_seen++;
        default:      errors_seen++;
      endcase
      if (expected_words.size() == 0) begin
        $error("result word %h arrived with nothing predicted", out_word);
        fail_count++;
      end else begin
        want = expected_words.pop_front();
        check_field("kind", want.kind, out_word.kind);
        check_field("payload_byte", want.payload_byte, out_word.payload_byte);
        check_field("arg_index", want.arg_index, out_word.arg_index);
        check_field("arg_end", want.arg_end, out_word.arg_end);
        check_field("request_end", want.request_end, out_word.request_end);
        check_field("error_code", want.error_code, out_word.error_code);
        results_checked++;
      end
    end
  end

  // pop side: a long hold-off when asked, else a per-word gap
  initial begin : result_sink
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_pop = 1'b0;
        hold_cycles--;
      end else if (rx_gap > 0) begin
        out_pop = 1'b0;
        rx_gap--;
      end else out_pop = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // three arguments: payload extremes with a CR inside, then two empty forms
  task automatic test_basic_request();
    put_line("*3");
    put_line("$3");
    put(8'h00);
    put(8'hFF);
    put(CH_CR);
    put_trail();
    put_line("$0");
    put(CH_STAR);
    put(CH_DOLLAR);
    put_line("$05");
    put_str("zz");   // after the last argument, dropped
    flush_words(1'b1, 1'b1);
    // widest count, one byte per argument, indexes 0 to 8
    put_line("*9");
    for (int i = 0; i < 9; i++) begin
      if (i > 0) put_trail();
      put_line("$1");
      put(8'h41 + i);
    end
    flush_words(1'b1, 1'b0);
  endtask

  task automatic test_header_errors();
    put_str("x");
    flush_words(1'b1, 1'b0);
    // a whole request without buffer start is dropped after an error
    put_line("*1");
    put_line("$1");
    put_str("A");
    flush_words(1'b0, 1'b0);
    put_str("*a");
    flush_words(1'b1, 1'b0);
    put_line("*1");
    put_str("#");
    flush_words(1'b1, 1'b0);
    // zero count ends after the header, no word
    put_line("*0");
    put_line("$1");
    put_str("B");
    flush_words(1'b1, 1'b1);
  endtask

  task automatic test_length_forms();
    put_line("*4");
    put_line("$");          // no digits at all
    put_trail();
    put_line("$2x");        // digits stop at a non-digit
    put_str("ab");
    put_trail();
    put_line("$x7");        // non-digit first, digits after it ignored
    put_trail();
    put_line("$99999999");  // saturates
    flush_words(1'b1, 1'b0);
  endtask

  task automatic test_length_limit();
    write_limit(3);
    put_line("*2");
    put_line("$3");
    put_str("abc");
    put_trail();
    put_line("$4");
    flush_words(1'b1, 1'b0);
    write_limit('0);
    put_line("*2");
    put_line("$0");
    put_trail();
    put_line("$1");
    put_str("q");
    flush_words(1'b1, 1'b0);
    write_limit('1);
    put_line("*1");
    put_line("$1048576");
    flush_words(1'b1, 1'b0);
    // widest legal length, cut off early by buffer end
    put_line("*1");
    put_line("$1048575");
    put_str("abc");
    flush_words(1'b1, 1'b1);
  endtask

  task automatic test_truncation();
    put(CH_STAR);
    flush_words(1'b1, 1'b1);
    put_str("x");           // header error wins over the end mark
    flush_words(1'b1, 1'b1);
    put_str("*2");
    put(CH_CR);
    flush_words(1'b1, 1'b1);
    put_line("*2");
    put_line("$1");
    put_str("A");
    put(CH_CR);             // ends between arguments
    flush_words(1'b1, 1'b1);
    // restart in the middle of a payload
    put_line("*1");
    put_line("$5");
    put_str("ab");
    flush_words(1'b1, 1'b0);
    put_line("*1");
    put_line("$1");
    put_str("Z");
    flush_words(1'b1, 1'b1);
  endtask

  // receiver stalls long enough for the input side to fill and push back
  task automatic test_backpressure();
    send_gap_max = 0;
    recv_gap_max = 0;
    hold_cycles  = 80;
    put_line("*1");
    put_line("$48");
    repeat (48) put($urandom);
    flush_words(1'b1, 1'b0);
    wait_idle();
  endtask

  function automatic logic [7:0] odd_byte();
    logic [7:0] b;
    do b = $urandom; while (b == CH_CR || is_digit(b));
    return b;
  endfunction

  // well-formed request with random content, sized to the current limit
  task automatic build_request();
    int       nargs;
    int       len;
    int       sel;
    in_word_t w;
    sel = $urandom_range(0, 15);
    nargs = (sel == 0) ? 0 : (sel == 1) ? 9 : $urandom_range(1, 4);
    w              = '0;
    w.data_byte    = CH_STAR;
    w.buffer_start = 1'b1;
    pend_q.push_back(w);
    put(CH_ZERO + nargs);
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) put(odd_byte());
    put(CH_CR);
    put($urandom);
    for (int a = 0; a < nargs; a++) begin
      if (a > 0) begin
        put($urandom);
        put($urandom);
      end
      put(CH_DOLLAR);
      sel = $urandom_range(0, 19);
      if (sel == 19) begin
        // eight or more digits always saturate
        put(CH_ONE + $urandom_range(0, 8));
        repeat ($urandom_range(7, 11)) put(CH_ZERO + $urandom_range(0, 9));
        put(CH_CR);
        put($urandom);
        break;
      end
      if (sel < 3) len = 0;
      else if (sel < 15) len = $urandom_range(1, 8);
      else if (sel < 18) len = $urandom_range(9, 30);
      else if (arg_len_limit <= 40 && $urandom_range(0, 1)) len = arg_len_limit;
      else len = int'(arg_len_limit) + 1;
      if (len == 0) begin
        case ($urandom_range(0, 3))
          0: put(CH_ZERO);
          1: begin
            put(CH_ZERO);
            repeat ($urandom_range(1, 3)) put(CH_ZERO + $urandom_range(0, 9));
          end
          2: ;
          default: repeat ($urandom_range(1, 3)) put(odd_byte());
        endcase
      end else begin
        put_str($sformatf("%0d", len));
        if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 2)) put(odd_byte());
      end
      put(CH_CR);
      put($urandom);
      if (len > arg_len_limit) break;  // rejected, nothing follows
      repeat (len) put($urandom);
    end
    if ($urandom_range(0, 1)) begin
      put($urandom);
      put($urandom);
    end
    pend_q[pend_q.size()-1].buffer_end = $urandom_range(0, 1);
    requests_built++;
  endtask

  // some requests get cut short, corrupted or followed by loose noise
  task automatic mangle_request();
    int unsigned cut;
    in_word_t    w;
    case ($urandom_range(0, 9))
      0, 1: begin
        cut = $urandom_range(0, pend_q.size() - 1);
        while (pend_q.size() > cut + 1) void'(pend_q.pop_back());
        pend_q[cut].buffer_end = $urandom_range(0, 1);
      end
      2: pend_q[$urandom_range(1, pend_q.size() - 1)].data_byte = $urandom;
      3: begin
        repeat ($urandom_range(1, 6)) begin
          w.data_byte    = $urandom;
          w.buffer_start = ($urandom_range(0, 3) == 0);
          w.buffer_end   = ($urandom_range(0, 3) == 0);
          pend_q.push_back(w);
        end
      end
      default: ;
    endcase
  endtask

  task automatic test_random();
    logic [RAP_ARG_LEN_BITS-1:0] limits[RAND_PHASES];
    int unsigned                 target;
    limits[0] = $urandom_range(0, 15);
    limits[1] = '0;
    limits[2] = '1;
    limits[3] = $urandom_range(41, LEN_CAP - 1);
    limits[4] = $urandom_range(16, 40);
    for (int p = 0; p < RAND_PHASES; p++) begin
      write_limit(limits[p]);
      // no idling, sender only, receiver only, then both
      send_gap_max = (p % 2 == 1 || p == 4) ? 15 : 0;
      recv_gap_max = (p >= 2) ? 15 : 0;
      target       = live_items + PHASE_ITEMS;
      while (live_items < target) begin
        build_request();
        mangle_request();
        flush_words(1'b0, 1'b0);
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_push       = 1'b0;
    in_word       = '0;
    out_pop       = 1'b0;
    cfg_we        = 1'b0;
    cfg_data      = '0;
    send_gap_max  = 0;
    recv_gap_max  = 0;
    rx_gap        = 0;
    hold_cycles   = 0;
    arg_len_limit = '1;
    prs_phase     = PH_IDLE;
    args_left     = '0;
    cur_arg       = '0;
    len_acc       = '0;
    pay_left      = '0;
    skip_left     = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    test_basic_request();
    test_header_errors();
    test_length_forms();
    test_length_limit();
    test_truncation();
    test_backpressure();
    test_random();
    wait_idle();

    $display("covered %0d words (%0d parsed, %0d full cycles) in %0d random requests",
             words_sent, live_items, stall_cycles, requests_built);
    $display("checked %0d results: %0d payload, %0d empty, %0d error; %0d limit writes",
             results_checked, payload_seen, empty_seen, errors_seen, limit_writes);
    if (fail_count == 0) $display("request_array_byte_parser_tb OK");
    else $display("request_array_byte_parser_tb NOT OK");
    $finish;
  end

endmodule
